// ===== rtl/jmhp_pkg.sv =====
// Shared types, byte codes and constants of the JPEG marker header parser.
`default_nettype none
package jmhp_pkg;

	localparam int FIFO_DEPTH = 4;
	localparam int FIFO_AW = $clog2(FIFO_DEPTH);
	localparam int OUT_TDATA_W = 40;

	localparam logic [7:0] BYTE_FILL  = 8'hFF;
	localparam logic [7:0] MK_SOI     = 8'hD8;
	localparam logic [7:0] MK_TEM     = 8'h01;
	localparam logic [7:0] MK_RST_LO  = 8'hD0;
	localparam logic [7:0] MK_RST_HI  = 8'hD7;
	localparam logic [7:0] MK_EOI     = 8'hD9;
	localparam logic [7:0] MK_SOS     = 8'hDA;
	localparam logic [7:0] MK_SOF_LO  = 8'hC0;
	localparam logic [7:0] MK_SOF_HI  = 8'hCF;
	localparam logic [7:0] MK_DHT     = 8'hC4;
	localparam logic [7:0] MK_JPG     = 8'hC8;
	localparam logic [7:0] MK_DAC     = 8'hCC;

	typedef enum logic [1:0] {
		ST_OK       = 2'd0,
		ST_TRUNC    = 2'd1,
		ST_NOT_JPEG = 2'd2,
		ST_NO_FRAME = 2'd3
	} status_t;

	typedef struct packed {
		logic [7:0] data;
		logic       last;
		logic       is_fill;
		logic       is_soi;
		logic       is_standalone;
		logic       is_end;
		logic       is_frame;
	} item_t;

	typedef struct packed {
		logic full;
		logic empty;
	} fifo_stat_t;

	function automatic item_t classify(input logic [7:0] b, input logic last);
		item_t it;
		it.data = b;
		it.last = last;
		it.is_fill = (b == BYTE_FILL);
		it.is_soi = (b == MK_SOI);
		it.is_standalone = (b == MK_SOI) || (b == MK_TEM) || (b >= MK_RST_LO && b <= MK_RST_HI);
		it.is_end = (b == MK_EOI) || (b == MK_SOS);
		it.is_frame = (b >= MK_SOF_LO) && (b <= MK_SOF_HI) && (b != MK_DHT) &&
			(b != MK_JPG) && (b != MK_DAC);
		return it;
	endfunction

endpackage
`default_nettype wire

// ===== rtl/jmhp_front.sv =====
// Input side: accepts stream words and tags each byte with its marker class.
`default_nettype none
module jmhp_front (
	input  wire logic             s_tvalid,
	output logic                  s_tready,
	input  wire logic [7:0]       s_tdata,
	input  wire logic             s_tlast,
	input  wire jmhp_pkg::fifo_stat_t stat,
	output logic                  push,
	output jmhp_pkg::item_t       push_item
);

	assign s_tready = !stat.full;
	assign push = s_tvalid && !stat.full;
	assign push_item = jmhp_pkg::classify(s_tdata, s_tlast);

endmodule
`default_nettype wire

// ===== rtl/jmhp_fifo.sv =====
// Short queue of classified bytes between the input side and the parser.
`default_nettype none
module jmhp_fifo (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             push,
	input  wire jmhp_pkg::item_t  push_item,
	input  wire logic             pop,
	output jmhp_pkg::item_t       head,
	output jmhp_pkg::fifo_stat_t  stat
);

	localparam int AW = jmhp_pkg::FIFO_AW;
	localparam int CW = AW + 1;

	jmhp_pkg::item_t mem_q [jmhp_pkg::FIFO_DEPTH];
	logic [AW-1:0] wr_ptr_q;
	logic [AW-1:0] rd_ptr_q;
	logic [CW-1:0] count_q;
	logic          do_push;
	logic          do_pop;

	assign stat.full = (count_q == CW'(jmhp_pkg::FIFO_DEPTH));
	assign stat.empty = (count_q == '0);
	assign do_push = push && !stat.full;
	assign do_pop = pop && !stat.empty;
	assign head = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= push_item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= AW'((CW'(wr_ptr_q) + CW'(1)) % CW'(jmhp_pkg::FIFO_DEPTH));
			end
			if (do_pop) begin
				rd_ptr_q <= AW'((CW'(rd_ptr_q) + CW'(1)) % CW'(jmhp_pkg::FIFO_DEPTH));
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + CW'(1);
			end else if (do_pop && !do_push) begin
				count_q <= count_q - CW'(1);
			end
		end
	end

endmodule
`default_nettype wire

// ===== rtl/jmhp_parse.sv =====
// Parser: walks the marker segments byte by byte and holds the result word.
`default_nettype none
module jmhp_parse (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire jmhp_pkg::item_t  head,
	input  wire jmhp_pkg::fifo_stat_t stat,
	output logic                  pop,
	output logic                  m_tvalid,
	input  wire logic             m_tready,
	output logic [jmhp_pkg::OUT_TDATA_W-1:0] m_tdata
);

	typedef enum logic [8:0] {
		PH_SOI0    = 9'b000000001,
		PH_SOI1    = 9'b000000010,
		PH_MARK    = 9'b000000100,
		PH_FILL    = 9'b000001000,
		PH_LENHI   = 9'b000010000,
		PH_LENLO   = 9'b000100000,
		PH_PAYLOAD = 9'b001000000,
		PH_DONE    = 9'b010000000,
		PH_NOTJPEG = 9'b100000000
	} phase_t;

	phase_t      ph_q, ph_d;
	logic        frame_q, frame_d;
	logic [7:0]  lenhi_q, lenhi_d;
	logic [15:0] rem_q, rem_d;
	logic [2:0]  idx_q, idx_d;
	logic [15:0] hgt_q, hgt_d;
	logic [7:0]  wh_q, wh_d;
	logic [7:0]  wl_q, wl_d;
	logic [15:0] fw_q, fw_d;
	logic [15:0] fh_q, fh_d;
	logic        seen_q, seen_d;
	logic        trunc_q, trunc_d;
	logic [2:0]  cnt_q, cnt_d;
	logic [15:0] seg_len;
	logic [15:0] width_w;
	logic [15:0] res_w, res_h;
	jmhp_pkg::status_t res_st;
	logic        out_valid_q;
	logic [15:0] out_w_q, out_h_q;
	jmhp_pkg::status_t out_st_q;

	assign pop = !stat.empty && (!head.last || !out_valid_q || m_tready);
	assign seg_len = {lenhi_q, head.data};
	assign width_w = {wh_d, wl_d};

	always_comb begin
		ph_d = ph_q;
		frame_d = frame_q;
		lenhi_d = lenhi_q;
		rem_d = rem_q;
		idx_d = idx_q;
		hgt_d = hgt_q;
		wh_d = wh_q;
		wl_d = wl_q;
		fw_d = fw_q;
		fh_d = fh_q;
		seen_d = seen_q;
		trunc_d = trunc_q;
		cnt_d = (cnt_q < 3'd4) ? cnt_q + 3'd1 : cnt_q;
		unique case (ph_q)
			PH_SOI0: begin
				ph_d = head.is_fill ? PH_SOI1 : PH_NOTJPEG;
			end
			PH_SOI1: begin
				ph_d = head.is_soi ? PH_MARK : PH_NOTJPEG;
			end
			PH_MARK: begin
				if (!head.last) begin
					if (!head.is_fill) begin
						trunc_d = 1'b1;
						ph_d = PH_DONE;
					end else begin
						ph_d = PH_FILL;
					end
				end
			end
			PH_FILL: begin
				if (head.is_fill) begin
					if (head.last) begin
						trunc_d = 1'b1;
						ph_d = PH_DONE;
					end
				end else begin
					frame_d = head.is_frame;
					if (head.is_standalone) begin
						ph_d = PH_MARK;
					end else if (head.is_end) begin
						ph_d = PH_DONE;
					end else if (head.last) begin
						trunc_d = 1'b1;
						ph_d = PH_DONE;
					end else begin
						ph_d = PH_LENHI;
					end
				end
			end
			PH_LENHI: begin
				lenhi_d = head.data;
				if (head.last) begin
					trunc_d = 1'b1;
					ph_d = PH_DONE;
				end else begin
					ph_d = PH_LENLO;
				end
			end
			PH_LENLO: begin
				if (seg_len < 16'd2) begin
					trunc_d = 1'b1;
					ph_d = PH_DONE;
				end else begin
					rem_d = seg_len - 16'd2;
					idx_d = 3'd0;
					if (rem_d == 16'd0) begin
						ph_d = PH_MARK;
					end else if (head.last) begin
						trunc_d = 1'b1;
						ph_d = PH_DONE;
					end else begin
						ph_d = PH_PAYLOAD;
					end
				end
			end
			PH_PAYLOAD: begin
				case (idx_q)
					3'd1: hgt_d = {head.data, 8'h00};
					3'd2: hgt_d = {hgt_q[15:8], hgt_q[7:0] | head.data};
					3'd3: wh_d = head.data;
					3'd4: wl_d = head.data;
					default: ;
				endcase
				idx_d = (idx_q < 3'd5) ? idx_q + 3'd1 : idx_q;
				rem_d = rem_q - 16'd1;
				if (rem_d == 16'd0) begin
					if (idx_d >= 3'd5 && frame_q && width_w != 16'd0 && hgt_d != 16'd0) begin
						fw_d = width_w;
						fh_d = hgt_d;
						seen_d = 1'b1;
					end
					ph_d = PH_MARK;
				end else if (head.last) begin
					trunc_d = 1'b1;
					ph_d = PH_DONE;
				end
			end
			PH_DONE, PH_NOTJPEG: ;
			default: ;
		endcase
	end

	always_comb begin
		if (ph_d == PH_NOTJPEG || cnt_d < 3'd4 || ph_d == PH_SOI0 || ph_d == PH_SOI1) begin
			res_w = 16'd0;
			res_h = 16'd0;
			res_st = jmhp_pkg::ST_NOT_JPEG;
		end else if (!seen_d) begin
			res_w = 16'd0;
			res_h = 16'd0;
			res_st = jmhp_pkg::ST_NO_FRAME;
		end else begin
			res_w = fw_d;
			res_h = fh_d;
			res_st = trunc_d ? jmhp_pkg::ST_TRUNC : jmhp_pkg::ST_OK;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ph_q <= PH_SOI0;
			frame_q <= 1'b0;
			lenhi_q <= '0;
			rem_q <= '0;
			idx_q <= '0;
			hgt_q <= '0;
			wh_q <= '0;
			wl_q <= '0;
			fw_q <= '0;
			fh_q <= '0;
			seen_q <= 1'b0;
			trunc_q <= 1'b0;
			cnt_q <= '0;
		end else if (pop) begin
			if (head.last) begin
				ph_q <= PH_SOI0;
				frame_q <= 1'b0;
				lenhi_q <= '0;
				rem_q <= '0;
				idx_q <= '0;
				hgt_q <= '0;
				wh_q <= '0;
				wl_q <= '0;
				fw_q <= '0;
				fh_q <= '0;
				seen_q <= 1'b0;
				trunc_q <= 1'b0;
				cnt_q <= '0;
			end else begin
				ph_q <= ph_d;
				frame_q <= frame_d;
				lenhi_q <= lenhi_d;
				rem_q <= rem_d;
				idx_q <= idx_d;
				hgt_q <= hgt_d;
				wh_q <= wh_d;
				wl_q <= wl_d;
				fw_q <= fw_d;
				fh_q <= fh_d;
				seen_q <= seen_d;
				trunc_q <= trunc_d;
				cnt_q <= cnt_d;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (pop && head.last) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (pop && head.last) begin
			out_w_q <= res_w;
			out_h_q <= res_h;
			out_st_q <= res_st;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata = {{(jmhp_pkg::OUT_TDATA_W - 34){1'b0}}, out_st_q, out_h_q, out_w_q};

endmodule
`default_nettype wire

// ===== rtl/jpeg_marker_header_parser.sv =====
// Top level of the JPEG marker header parser.
`default_nettype none
// Feed a JPEG file one byte per word with tlast on its final byte; one result
// word follows each file with width, height and status. A byte is taken every
// cycle: the input side tags bytes into a four-entry queue and the parser
// consumes one queued byte per cycle, so the only stall is a final byte that
// waits while the previous result word is still held in the output register.
module jpeg_marker_header_parser (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_tvalid,
	output logic             s_tready,
	input  wire logic [7:0]  s_tdata,   // data_byte[7:0]
	input  wire logic        s_tlast,
	output logic             m_tvalid,
	input  wire logic        m_tready,
	output logic [39:0]      m_tdata    // image_width[15:0], image_height[31:16], parse_status[33:32]
);

	jmhp_pkg::fifo_stat_t stat;
	jmhp_pkg::item_t      push_item;
	jmhp_pkg::item_t      head;
	logic                 push;
	logic                 pop;

	jmhp_front u_front (
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tlast  (s_tlast),
		.stat     (stat),
		.push     (push),
		.push_item(push_item)
	);

	jmhp_fifo u_fifo (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_item(push_item),
		.pop      (pop),
		.head     (head),
		.stat     (stat)
	);

	jmhp_parse u_parse (
		.clk     (clk),
		.arst_n  (arst_n),
		.head    (head),
		.stat    (stat),
		.pop     (pop),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata (m_tdata)
	);

	a_not_full_and_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!(stat.full && stat.empty))
		else $error("Queue reports full and empty at once.");

	a_no_pop_when_empty: assert property (@(posedge clk) disable iff (!arst_n)
		stat.empty |-> !pop)
		else $error("Parser consumed a byte from an empty queue.");

	a_result_from_last: assert property (@(posedge clk) disable iff (!arst_n)
		(pop && head.last) |=> m_tvalid)
		else $error("Final byte consumed without a result word.");

	a_result_not_overwritten: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && !m_tready) |-> !(pop && head.last))
		else $error("Pending result word would be overwritten.");

endmodule
`default_nettype wire

// ===== tb/jpeg_marker_header_parser_tb.sv =====
// Self-checking testbench for the JPEG marker header parser: directed files, then random files.
`timescale 1ns / 1ps
module jpeg_marker_header_parser_tb;

	localparam int BYTE_TARGET = 1400;
	localparam int CYCLE_LIMIT = 400000;
	localparam int HOLD_CYCLES = 400;
	localparam int N_ROWS = 27;

	typedef enum logic [3:0] {
		WAIT_SOI0, WAIT_SOI1, WAIT_MARK, IN_FILL, LEN_HI, LEN_LO, IN_PAYLOAD, STOPPED, NOT_JPEG
	} scan_phase_t;

	typedef struct packed {
		logic [15:0]       width;
		logic [15:0]       height;
		jmhp_pkg::status_t status;
	} dims_t;

	typedef struct packed {
		logic [7:0] data;
		logic       last;
		logic       typed;
		dims_t      res;
	} row_t;

	localparam row_t DIRECTED [0:N_ROWS-1] = '{
		'{jmhp_pkg::BYTE_FILL, 1'b0, 1'b0, '{16'h0000, 16'h0000, jmhp_pkg::ST_OK}},
		'{jmhp_pkg::MK_SOI,    1'b1, 1'b1, '{16'h0000, 16'h0000, jmhp_pkg::ST_NOT_JPEG}},
		'{8'h00,               1'b0, 1'b0, '{16'h0000, 16'h0000, jmhp_pkg::ST_OK}},
		'{jmhp_pkg::MK_SOI,    1'b0, 1'b0, '{16'h0000, 16'h0000, jmhp_pkg::ST_OK}},
		'{jmhp_pkg::BYTE_FILL, 1'b0, 1'b0, '{16'h0000, 16'h0000, jmhp_pkg::ST_OK}},
		'{jmhp_pkg::MK_EOI,    1'b1, 1'b1, '{16'h0000, 16'h0000, jmhp_pkg::ST_NOT_JPEG}},
		'{jmhp_pkg::BYTE_FILL, 1'b0, 1'b0, '{16'h0000, 16'h0000, jmhp_pkg::ST_OK}},
		'{jmhp_pkg::MK_SOI,    1'b0, 1'b0, '{16'h0000, 16'h0000, jmhp_pkg::ST_OK}},
		'{jmhp_pkg::BYTE_FILL, 1'b0, 1'b0, '{16'h0000, 16'h0000, jmhp_pkg::ST_OK}},
		'{jmhp_pkg::MK_SOF_LO, 1'b0, 1'b0, '{16'h0000, 16'h0000, jmhp_pkg::ST_OK}},
		'{8'h00,               1'b0, 1'b0, '{16'h0000, 16'h0000, jmhp_pkg::ST_OK}},
		'{8'h07,               1'b0, 1'b0, '{16'h0000, 16'h0000, jmhp_pkg::ST_OK}},
		'{8'h08,               1'b0, 1'b0, '{16'h0000, 16'h0000, jmhp_pkg::ST_OK}},
		'{8'hFF,               1'b0, 1'b0, '{16'h0000, 16'h0000, jmhp_pkg::ST_OK}},
		'{8'hFF,               1'b0, 1'b0, '{16'h0000, 16'h0000, jmhp_pkg::ST_OK}},
		'{8'hFF,               1'b0, 1'b0, '{16'h0000, 16'h0000, jmhp_pkg::ST_OK}},
		'{8'hFF,               1'b0, 1'b0, '{16'h0000, 16'h0000, jmhp_pkg::ST_OK}},
		'{jmhp_pkg::BYTE_FILL, 1'b0, 1'b0, '{16'h0000, 16'h0000, jmhp_pkg::ST_OK}},
		'{jmhp_pkg::MK_EOI,    1'b1, 1'b1, '{16'hFFFF, 16'hFFFF, jmhp_pkg::ST_OK}},
		'{jmhp_pkg::BYTE_FILL, 1'b0, 1'b0, '{16'h0000, 16'h0000, jmhp_pkg::ST_OK}},
		'{jmhp_pkg::MK_SOI,    1'b0, 1'b0, '{16'h0000, 16'h0000, jmhp_pkg::ST_OK}},
		'{jmhp_pkg::BYTE_FILL, 1'b0, 1'b0, '{16'h0000, 16'h0000, jmhp_pkg::ST_OK}},
		'{jmhp_pkg::MK_EOI,    1'b1, 1'b1, '{16'h0000, 16'h0000, jmhp_pkg::ST_NO_FRAME}},
		'{jmhp_pkg::BYTE_FILL, 1'b0, 1'b0, '{16'h0000, 16'h0000, jmhp_pkg::ST_OK}},
		'{jmhp_pkg::MK_SOI,    1'b0, 1'b0, '{16'h0000, 16'h0000, jmhp_pkg::ST_OK}},
		'{jmhp_pkg::BYTE_FILL, 1'b0, 1'b0, '{16'h0000, 16'h0000, jmhp_pkg::ST_OK}},
		'{jmhp_pkg::BYTE_FILL, 1'b1, 1'b1, '{16'h0000, 16'h0000, jmhp_pkg::ST_NO_FRAME}}
	};

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [7:0]  s_tdata = 8'h00;
	logic        s_tlast = 1'b0;
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [39:0] m_tdata;

	logic        calm = 1'b0;
	logic        hold_request = 1'b0;
	logic        hold_used = 1'b0;
	int          hold_left = 0;
	int          cycles = 0;
	int          errors = 0;

	dims_t       want_dims[$];
	logic [7:0]  file_bytes[$];

	scan_phase_t p_phase;
	logic [7:0]  p_marker;
	logic [7:0]  p_lenhi;
	logic [15:0] p_remain;
	logic [2:0]  p_index;
	logic [15:0] p_height;
	logic [7:0]  p_wide_hi;
	logic [15:0] p_found_w;
	logic [15:0] p_found_h;
	logic        p_frame;
	logic        p_trunc;
	logic [2:0]  p_count;

	jpeg_marker_header_parser DUT (
		.clk(clk),
		.arst_n(arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.s_tlast(s_tlast),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("jpeg_marker_header_parser_tb failed");
			$finish;
		end
	end

	always @(posedge clk) begin
		if (hold_request && !hold_used) begin
			hold_used <= 1'b1;
			hold_left <= HOLD_CYCLES;
			m_tready <= 1'b0;
		end else if (hold_left != 0) begin
			hold_left <= hold_left - 1;
			m_tready <= 1'b0;
		end else if (calm) begin
			m_tready <= 1'b1;
		end else begin
			m_tready <= ($urandom_range(99) >= 31);
		end
	end

	always @(posedge clk) begin
		dims_t want;
		if (arst_n && m_tvalid && m_tready) begin
			if (want_dims.size() == 0) begin
				$error("unexpected result word: %h", m_tdata);
				errors++;
			end else begin
				want = want_dims.pop_front();
				if (m_tdata[15:0] !== want.width) begin
					$error("image_width: expected %0d, got %0d", want.width, m_tdata[15:0]);
					errors++;
				end
				if (m_tdata[31:16] !== want.height) begin
					$error("image_height: expected %0d, got %0d", want.height, m_tdata[31:16]);
					errors++;
				end
				if (m_tdata[33:32] !== want.status) begin
					$error("parse_status: expected %0d, got %0d", want.status, m_tdata[33:32]);
					errors++;
				end
			end
		end
	end

	task automatic clear_scan();
		p_phase = WAIT_SOI0;
		p_marker = 8'h00;
		p_lenhi = 8'h00;
		p_remain = 16'h0000;
		p_index = 3'd0;
		p_height = 16'h0000;
		p_wide_hi = 8'h00;
		p_found_w = 16'h0000;
		p_found_h = 16'h0000;
		p_frame = 1'b0;
		p_trunc = 1'b0;
		p_count = 3'd0;
	endtask

	task automatic stop_truncated();
		p_trunc = 1'b1;
		p_phase = STOPPED;
	endtask

	task automatic predict_byte(input logic [7:0] b, input logic last, output bit emits,
			output dims_t r);
		logic [15:0] seg_len;
		logic [15:0] w;
		logic [2:0]  idx;
		if (p_count < 3'd4)
			p_count = p_count + 3'd1;
		case (p_phase)
			WAIT_SOI0: p_phase = (b == jmhp_pkg::BYTE_FILL) ? WAIT_SOI1 : NOT_JPEG;
			WAIT_SOI1: p_phase = (b == jmhp_pkg::MK_SOI) ? WAIT_MARK : NOT_JPEG;
			WAIT_MARK: begin
				if (!last) begin
					if (b != jmhp_pkg::BYTE_FILL)
						stop_truncated();
					else
						p_phase = IN_FILL;
				end
			end
			IN_FILL: begin
				if (b == jmhp_pkg::BYTE_FILL) begin
					if (last)
						stop_truncated();
				end else begin
					p_marker = b;
					if (b == jmhp_pkg::MK_SOI || b == jmhp_pkg::MK_TEM ||
							(b >= jmhp_pkg::MK_RST_LO && b <= jmhp_pkg::MK_RST_HI))
						p_phase = WAIT_MARK;
					else if (b == jmhp_pkg::MK_EOI || b == jmhp_pkg::MK_SOS)
						p_phase = STOPPED;
					else if (last)
						stop_truncated();
					else
						p_phase = LEN_HI;
				end
			end
			LEN_HI: begin
				p_lenhi = b;
				if (last)
					stop_truncated();
				else
					p_phase = LEN_LO;
			end
			LEN_LO: begin
				seg_len = {p_lenhi, b};
				if (seg_len < 16'd2) begin
					stop_truncated();
				end else begin
					p_remain = seg_len - 16'd2;
					p_index = 3'd0;
					if (p_remain == 16'd0)
						p_phase = WAIT_MARK;
					else if (last)
						stop_truncated();
					else
						p_phase = IN_PAYLOAD;
				end
			end
			IN_PAYLOAD: begin
				idx = p_index;
				case (idx)
					3'd1: p_height = {b, 8'h00};
					3'd2: p_height = p_height | {8'h00, b};
					3'd3: p_wide_hi = b;
					3'd4: p_lenhi = b;
					default: ;
				endcase
				if (idx < 3'd5)
					p_index = idx + 3'd1;
				p_remain = p_remain - 16'd1;
				if (p_remain == 16'd0) begin
					w = {p_wide_hi, p_lenhi};
					if (p_index >= 3'd5 && p_marker >= jmhp_pkg::MK_SOF_LO &&
							p_marker <= jmhp_pkg::MK_SOF_HI &&
							p_marker != jmhp_pkg::MK_DHT && p_marker != jmhp_pkg::MK_JPG &&
							p_marker != jmhp_pkg::MK_DAC &&
							w != 16'd0 && p_height != 16'd0) begin
						p_found_w = w;
						p_found_h = p_height;
						p_frame = 1'b1;
					end
					p_phase = WAIT_MARK;
				end else if (last) begin
					stop_truncated();
				end
			end
			default: ;
		endcase
		emits = last;
		r = '{16'h0000, 16'h0000, jmhp_pkg::ST_NOT_JPEG};
		if (last) begin
			if (p_phase == NOT_JPEG || p_count < 3'd4 || p_phase == WAIT_SOI0 ||
					p_phase == WAIT_SOI1)
				r.status = jmhp_pkg::ST_NOT_JPEG;
			else if (!p_frame)
				r.status = jmhp_pkg::ST_NO_FRAME;
			else
				r = '{p_found_w, p_found_h, p_trunc ? jmhp_pkg::ST_TRUNC : jmhp_pkg::ST_OK};
			clear_scan();
		end
	endtask

	task automatic drive_byte(input logic [7:0] b, input logic last);
		if (!calm) begin
			while ($urandom_range(99) < 31) begin
				s_tvalid <= 1'b0;
				@(posedge clk);
			end
		end
		s_tvalid <= 1'b1;
		s_tdata <= b;
		s_tlast <= last;
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
	endtask

	task automatic build_file();
		int          kind;
		int          pick;
		int          plen;
		int          cut;
		logic [7:0]  mk;
		logic [15:0] h;
		logic [15:0] w;
		logic [15:0] slen;
		file_bytes.delete();
		kind = $urandom_range(99);
		if (kind < 12) begin
			repeat ($urandom_range(8, 1))
				file_bytes.push_back(8'($urandom_range(255)));
			if ($urandom_range(1))
				file_bytes[0] = jmhp_pkg::BYTE_FILL;
		end else if (kind < 20) begin
			file_bytes.push_back(jmhp_pkg::BYTE_FILL);
			if ($urandom_range(1))
				file_bytes.push_back(jmhp_pkg::MK_SOI);
			if ($urandom_range(1))
				file_bytes.push_back(8'($urandom_range(255)));
		end else begin
			file_bytes.push_back(jmhp_pkg::BYTE_FILL);
			file_bytes.push_back(jmhp_pkg::MK_SOI);
			repeat ($urandom_range(5)) begin
				if ($urandom_range(3) == 0)
					repeat ($urandom_range(3, 1))
						file_bytes.push_back(jmhp_pkg::BYTE_FILL);
				file_bytes.push_back(jmhp_pkg::BYTE_FILL);
				pick = $urandom_range(99);
				if (pick < 20) begin
					case ($urandom_range(9))
						0: mk = jmhp_pkg::MK_TEM;
						1: mk = jmhp_pkg::MK_SOI;
						default: mk = 8'(jmhp_pkg::MK_RST_LO + $urandom_range(7));
					endcase
					file_bytes.push_back(mk);
				end else if (pick < 55) begin
					mk = 8'(jmhp_pkg::MK_SOF_LO + $urandom_range(15));
					plen = (pick < 25) ? $urandom_range(4) : $urandom_range(9, 5);
					h = ($urandom_range(7) == 0) ? 16'h0000 :
						($urandom_range(7) == 0) ? 16'hFFFF : 16'($urandom_range(65535));
					w = ($urandom_range(7) == 0) ? 16'h0000 :
						($urandom_range(7) == 0) ? 16'hFFFF : 16'($urandom_range(65535));
					slen = 16'(plen + 2);
					file_bytes.push_back(mk);
					file_bytes.push_back(slen[15:8]);
					file_bytes.push_back(slen[7:0]);
					for (int j = 0; j < plen; j++) begin
						case (j)
							1: file_bytes.push_back(h[15:8]);
							2: file_bytes.push_back(h[7:0]);
							3: file_bytes.push_back(w[15:8]);
							4: file_bytes.push_back(w[7:0]);
							default: file_bytes.push_back(8'($urandom_range(255)));
						endcase
					end
				end else begin
					mk = 8'($urandom_range(254));
					pick = $urandom_range(99);
					if (pick < 5)
						slen = 16'($urandom_range(1));
					else if (pick < 8)
						slen = 16'($urandom_range(600, 200));
					else
						slen = 16'($urandom_range(12, 2));
					file_bytes.push_back(mk);
					file_bytes.push_back(slen[15:8]);
					file_bytes.push_back(slen[7:0]);
					if (slen >= 16'd2)
						repeat (slen - 2)
							file_bytes.push_back(8'($urandom_range(255)));
				end
			end
			pick = $urandom_range(99);
			if (pick < 45) begin
				file_bytes.push_back(jmhp_pkg::BYTE_FILL);
				file_bytes.push_back(jmhp_pkg::MK_EOI);
			end else if (pick < 60) begin
				file_bytes.push_back(jmhp_pkg::BYTE_FILL);
				file_bytes.push_back(jmhp_pkg::MK_SOS);
				repeat ($urandom_range(6))
					file_bytes.push_back(8'($urandom_range(255)));
			end else if (pick < 70) begin
				file_bytes.push_back(jmhp_pkg::BYTE_FILL);
			end else if (pick < 80) begin
				file_bytes.push_back(jmhp_pkg::BYTE_FILL);
				file_bytes.push_back(8'($urandom_range(255)));
			end
			if ($urandom_range(3) == 0 && file_bytes.size() > 3) begin
				cut = $urandom_range(file_bytes.size() - 1, 3);
				while (file_bytes.size() > cut)
					void'(file_bytes.pop_back());
			end
		end
	endtask

	task automatic send_file();
		bit    emits;
		dims_t pred;
		for (int k = 0; k < file_bytes.size(); k++) begin
			drive_byte(file_bytes[k], k == file_bytes.size() - 1);
			predict_byte(file_bytes[k], k == file_bytes.size() - 1, emits, pred);
			if (emits)
				want_dims.push_back(pred);
		end
	endtask

	initial begin
		bit    emits;
		dims_t pred;
		int    sent;
		int    file_idx;
		clear_scan();
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		for (int row = 0; row < N_ROWS; row++) begin
			drive_byte(DIRECTED[row].data, DIRECTED[row].last);
			predict_byte(DIRECTED[row].data, DIRECTED[row].last, emits, pred);
			if (emits)
				want_dims.push_back(DIRECTED[row].typed ? DIRECTED[row].res : pred);
		end
		sent = 0;
		file_idx = 0;
		while (sent < BYTE_TARGET) begin
			if (file_idx == 4)
				hold_request <= 1'b1;
			if (file_idx == 20)
				calm <= 1'b1;
			if (file_idx == 36)
				calm <= 1'b0;
			build_file();
			send_file();
			sent += file_bytes.size();
			file_idx++;
			if (file_idx == 12) begin
				s_tvalid <= 1'b0;
				@(posedge clk);
				while (want_dims.size() != 0)
					@(posedge clk);
			end
		end
		s_tvalid <= 1'b0;
		while (want_dims.size() != 0)
			@(posedge clk);
		repeat (20) @(posedge clk);
		if (errors == 0) begin
			$display("jpeg_marker_header_parser_tb passed");
		end else begin
			$display("jpeg_marker_header_parser_tb failed");
		end
		$finish;
	end

endmodule
